>>> design/avsdc_pkg.sv
package avsdc_pkg;

    localparam int RATE_W      = 18;
    localparam int JIT_W       = 10;
    localparam int THR_W       = 24;
    localparam int DELAY_W     = 32;
    localparam int DELAY_MAG_W = 31;
    localparam int DRIFT_W     = 46;
    localparam int POS_W       = 42;
    localparam int UND_W       = 32;
    localparam int CORR_W      = 3;

    // Widest timestamp is 62 bits, so drift arithmetic fits in 64 bits.
    localparam int WIDE_W      = 64;
    localparam int HALF_W      = 32;

    localparam int unsigned US_PER_S  = 1000000;
    localparam int unsigned US_PER_MS = 1000;

    // Division by one million is a six-bit shift followed by a division by
    // 15625, which takes one quotient digit at a time by reciprocal multiplication.
    localparam int          DIV_SHIFT = 6;
    localparam int unsigned DIV_ODD   = US_PER_S >> DIV_SHIFT;
    localparam int          DIG_W     = 18;
    localparam int          REM_W     = 14;
    localparam int          RCP_W     = 33;
    localparam int          RCP_SH    = 46;
    // The reciprocal is 2^46 / 15625 rounded up, exact for any 32-bit partial dividend.
    localparam logic [RCP_W-1:0] DIV_RECIP = 33'd4503599628;

    localparam int QUEUE_DEPTH = 4;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_SAMPLE_RATE    = 2'd0;
    localparam logic [1:0] REG_JITTER_DEPTH   = 2'd1;
    localparam logic [1:0] REG_CORRECTION_THR = 2'd2;
    localparam logic [1:0] REG_RESAMPLE_THR   = 2'd3;

    localparam logic [RATE_W-1:0] SAMPLE_RATE_RST    = RATE_W'(48000);
    localparam logic [JIT_W-1:0]  JITTER_DEPTH_RST   = JIT_W'(40);
    localparam logic [THR_W-1:0]  CORRECTION_THR_RST = THR_W'(1000);
    localparam logic [THR_W-1:0]  RESAMPLE_THR_RST   = THR_W'(20000);

    typedef enum logic [CORR_W-1:0] {
        CORR_NONE          = 3'd0,
        CORR_STRETCH_AUDIO = 3'd1,
        CORR_SHRINK_AUDIO  = 3'd2,
        CORR_HOLD_VIDEO    = 3'd3,
        CORR_DROP_VIDEO    = 3'd4
    } t_corr;

    typedef enum logic [1:0] {
        KIND_VIDEO         = 2'd0,
        KIND_AUDIO_TIMED   = 2'd1,
        KIND_AUDIO_UNTIMED = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  xrun;
    } t_ctl;

    typedef struct packed {
        logic [RATE_W-1:0] sample_rate_hz;
        logic [JIT_W-1:0]  jitter_depth_ms;
        logic [THR_W-1:0]  correction_threshold;
        logic [THR_W-1:0]  resample_threshold;
    } t_cfg;

endpackage

>>> design/av_sync_drift_classifier.sv
// Audio/video drift classifier. Each beat is a video frame timestamp or an
// audio poll; every accepted beat yields exactly one result beat carrying the
// current drift, the chosen correction, the audio play position, the underrun
// count and whether both timestamps are known. Input beats enter a four-deep
// queue ahead of the execution sequencer, so while a result waits the queue
// still takes four beats and the sequencer holds one more. A video beat and
// an audio beat without valid timing skip the division; an audio beat with
// valid timing divides timestamp times sample rate by one million: a six-bit
// shift, then a division by 15625 that yields one 18-bit quotient digit per
// S_DIV/S_REM pass by reciprocal multiplication. A result held back by the
// output side stalls the sequencer. Registers sit at byte addresses 0 (sample
// rate), 4 (jitter depth), 8 (correction threshold) and 12 (resample
// threshold) and are to be written only while the block is idle.
// No clearing pass is needed after reset. TIME_WIDTH may range from 32 to 62.
module av_sync_drift_classifier #(
    parameter int TIME_WIDTH = 44
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_action,
    input  logic [TIME_WIDTH-1:0]                  i_timestamp_us,
    input  logic signed [avsdc_pkg::DELAY_W-1:0]   i_delay_frames,
    input  logic                                   i_xrun,
    input  logic                                   i_timing_valid,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [avsdc_pkg::DRIFT_W-1:0]   o_drift_out,
    output logic [avsdc_pkg::CORR_W-1:0]           o_correction,
    output logic [avsdc_pkg::POS_W-1:0]            o_position_frames,
    output logic [avsdc_pkg::UND_W-1:0]            o_underruns,
    output logic                                   o_drift_ready,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [avsdc_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [avsdc_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [avsdc_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                   pready
);
    import avsdc_pkg::*;

    localparam int CTL_W = $bits(t_ctl);
    localparam int QW    = CTL_W + DELAY_MAG_W + TIME_WIDTH;

    t_cfg                   r_cfg;
    logic                   w_push;
    logic                   w_full;
    logic                   w_pop;
    logic                   w_empty;
    t_ctl                   w_ctl;
    logic [DELAY_MAG_W-1:0] w_delay;
    logic [QW-1:0]          w_qin;
    logic [QW-1:0]          w_qout;
    t_ctl                   w_hd_ctl;
    logic [DELAY_MAG_W-1:0] w_hd_delay;
    logic [TIME_WIDTH-1:0]  w_hd_ts;
    logic                   w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_rate_hz       <= SAMPLE_RATE_RST;
            r_cfg.jitter_depth_ms      <= JITTER_DEPTH_RST;
            r_cfg.correction_threshold <= CORRECTION_THR_RST;
            r_cfg.resample_threshold   <= RESAMPLE_THR_RST;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_SAMPLE_RATE:    r_cfg.sample_rate_hz       <= pwdata[RATE_W-1:0];
                REG_JITTER_DEPTH:   r_cfg.jitter_depth_ms      <= pwdata[JIT_W-1:0];
                REG_CORRECTION_THR: r_cfg.correction_threshold <= pwdata[THR_W-1:0];
                REG_RESAMPLE_THR:   r_cfg.resample_threshold   <= pwdata[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SAMPLE_RATE:    prdata = APB_DATA_W'(r_cfg.sample_rate_hz);
            REG_JITTER_DEPTH:   prdata = APB_DATA_W'(r_cfg.jitter_depth_ms);
            REG_CORRECTION_THR: prdata = APB_DATA_W'(r_cfg.correction_threshold);
            REG_RESAMPLE_THR:   prdata = APB_DATA_W'(r_cfg.resample_threshold);
            default:            prdata = '0;
        endcase
    end

    avsdc_front u_front (
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_delay_frames (i_delay_frames),
        .i_xrun         (i_xrun),
        .i_timing_valid (i_timing_valid),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_ctl          (w_ctl),
        .o_delay        (w_delay)
    );

    assign w_qin = {w_ctl, w_delay, i_timestamp_us};

    avsdc_queue #(
        .DW    (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_qin),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_qout),
        .o_empty (w_empty)
    );

    assign w_hd_ctl   = t_ctl'(w_qout[QW-1 -: CTL_W]);
    assign w_hd_delay = w_qout[TIME_WIDTH +: DELAY_MAG_W];
    assign w_hd_ts    = w_qout[TIME_WIDTH-1:0];

    avsdc_back #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (w_empty),
        .o_pop             (w_pop),
        .i_ctl             (w_hd_ctl),
        .i_ts              (w_hd_ts),
        .i_delay           (w_hd_delay),
        .i_cfg             (r_cfg),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_drift_out       (o_drift_out),
        .o_correction      (o_correction),
        .o_position_frames (o_position_frames),
        .o_underruns       (o_underruns),
        .o_drift_ready     (o_drift_ready)
    );

`ifndef SYNTHESIS
    // A beat pushed into an empty queue leaves it non-empty once the push is registered.
    a_queue_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_empty) |=> !w_empty)
        else $error("queue lost a pushed beat");

    // Stretching audio or holding video follows a positive drift.
    a_positive_drift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_correction == CORR_STRETCH_AUDIO ||
                     o_correction == CORR_HOLD_VIDEO)) |-> (o_drift_out > 0))
        else $error("stretch or hold reported with a drift that is not positive");

    a_nonpositive_drift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_correction == CORR_SHRINK_AUDIO ||
                     o_correction == CORR_DROP_VIDEO)) |-> (o_drift_out <= 0))
        else $error("shrink or drop reported with a positive drift");
`endif

endmodule

>>> design/avsdc_front.sv
module avsdc_front (
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_action,
    input  logic signed [avsdc_pkg::DELAY_W-1:0]   i_delay_frames,
    input  logic                                   i_xrun,
    input  logic                                   i_timing_valid,
    input  logic                                   i_full,
    output logic                                   o_push,
    output avsdc_pkg::t_ctl                        o_ctl,
    output logic [avsdc_pkg::DELAY_MAG_W-1:0]      o_delay
);
    import avsdc_pkg::*;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        if (!i_action) begin
            o_ctl.kind = KIND_VIDEO;
        end else if (i_timing_valid) begin
            o_ctl.kind = KIND_AUDIO_TIMED;
        end else begin
            o_ctl.kind = KIND_AUDIO_UNTIMED;
        end
        // Underrun flags mean nothing on video beats.
        o_ctl.xrun = i_action && i_xrun;
    end

    // A negative delay counts as no delay.
    assign o_delay = i_delay_frames[DELAY_W-1] ? '0 : i_delay_frames[DELAY_MAG_W-1:0];

endmodule

>>> design/avsdc_queue.sv
module avsdc_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output logic          o_empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DW-1:0]    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

>>> design/avsdc_back.sv
module avsdc_back #(
    parameter int TIME_WIDTH = 44
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_empty,
    output logic                                  o_pop,
    input  avsdc_pkg::t_ctl                       i_ctl,
    input  logic [TIME_WIDTH-1:0]                 i_ts,
    input  logic [avsdc_pkg::DELAY_MAG_W-1:0]     i_delay,
    input  avsdc_pkg::t_cfg                       i_cfg,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [avsdc_pkg::DRIFT_W-1:0]  o_drift_out,
    output logic [avsdc_pkg::CORR_W-1:0]          o_correction,
    output logic [avsdc_pkg::POS_W-1:0]           o_position_frames,
    output logic [avsdc_pkg::UND_W-1:0]           o_underruns,
    output logic                                  o_drift_ready
);
    import avsdc_pkg::*;

    localparam int PROD_W    = TIME_WIDTH + RATE_W;
    localparam int QUO_W     = PROD_W - DIV_SHIFT;
    localparam int DIV_STEPS = (QUO_W + DIG_W - 1) / DIG_W;
    localparam int DVD_W     = DIV_STEPS * DIG_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int PART_W    = HALF_W + RATE_W;
    localparam int SUM_W     = PART_W + HALF_W;
    localparam int JMUL_W    = JIT_W + 10;
    localparam int V_W       = REM_W + DIG_W;
    localparam int QP_W      = V_W + RCP_W;
    localparam logic signed [WIDE_W-1:0] DRIFT_MAX64 =
        (WIDE_W'(64'sd1) <<< (DRIFT_W - 1)) - WIDE_W'(64'sd1);
    localparam logic signed [WIDE_W-1:0] DRIFT_MIN64 = -DRIFT_MAX64 - WIDE_W'(64'sd1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_DIV,
        S_REM,
        S_POS,
        S_DRIFT,
        S_SAT,
        S_CLASS,
        S_OUT
    } t_state;

    t_state                      r_state;
    logic [TIME_WIDTH-1:0]       r_ts;
    logic [DELAY_MAG_W-1:0]      r_delay;
    logic [PART_W-1:0]           r_plo;
    logic [PART_W-1:0]           r_phi;
    logic [DVD_W-1:0]            r_dvd;
    logic [REM_W-1:0]            r_rem;
    logic [V_W-1:0]              r_v;
    logic [DIG_W-1:0]            r_qdig;
    logic [CNT_W-1:0]            r_cnt;
    logic [TIME_WIDTH-1:0]       r_video;
    logic [TIME_WIDTH-1:0]       r_audio;
    logic signed [WIDE_W-1:0]    r_dfull;
    logic signed [DRIFT_W-1:0]   r_drift;
    t_corr                       r_corr;
    logic [POS_W-1:0]            r_pos;
    logic [UND_W-1:0]            r_und;
    logic                        r_ovalid;
    logic signed [DRIFT_W-1:0]   r_odrift;
    t_corr                       r_ocorr;
    logic [POS_W-1:0]            r_opos;
    logic [UND_W-1:0]            r_ound;
    logic                        r_ordy;

    logic [WIDE_W-1:0]           w_ts_wide;
    logic [PART_W-1:0]           w_plo;
    logic [PART_W-1:0]           w_phi;
    logic [SUM_W-1:0]            w_prod;
    logic [V_W-1:0]              w_v;
    logic [QP_W-1:0]             w_qprod;
    logic [DIG_W-1:0]            w_qdig;
    logic [V_W-1:0]              w_qd;
    logic [DVD_W:0]              w_diff;
    logic [POS_W-1:0]            n_pos;
    logic [JMUL_W-1:0]           w_jit_us;
    logic [WIDE_W-1:0]           w_dsum;
    logic signed [DRIFT_W-1:0]   n_drift;
    logic [DRIFT_W-1:0]          w_mag;
    logic                        w_positive;
    t_corr                       n_corr;
    logic                        w_both;

    assign o_pop = (r_state == S_IDLE) && !i_empty;
    assign w_both = (r_video != '0) && (r_audio != '0);

    // The product is split in halves so that each multiplier stays narrow.
    assign w_ts_wide = WIDE_W'(r_ts);
    assign w_plo = PART_W'(w_ts_wide[HALF_W-1:0]) * PART_W'(i_cfg.sample_rate_hz);
    assign w_phi = PART_W'(w_ts_wide[WIDE_W-1:HALF_W]) * PART_W'(i_cfg.sample_rate_hz);
    assign w_prod = {r_phi, HALF_W'(0)} + SUM_W'(r_plo);

    // Long division by 15625, one 18-bit digit per S_DIV/S_REM pass. The partial
    // dividend (remainder above the next digit) stays below 2^32, so the
    // reciprocal product gives the exact quotient digit. Dividend digits leave
    // at the top while quotient digits enter at the bottom.
    assign w_v     = {r_rem, r_dvd[DVD_W-1 -: DIG_W]};
    assign w_qprod = QP_W'(w_v) * QP_W'(DIV_RECIP);
    assign w_qdig  = w_qprod[RCP_SH +: DIG_W];
    assign w_qd    = V_W'(r_qdig) * V_W'(DIV_ODD);

    assign w_diff = {1'b0, r_dvd} - (DVD_W + 1)'(r_delay);

    always_comb begin
        if (w_diff[DVD_W]) begin
            n_pos = '0;
        end else if (|w_diff[DVD_W-1:POS_W]) begin
            n_pos = '1;
        end else begin
            n_pos = w_diff[POS_W-1:0];
        end
    end

    assign w_jit_us = JMUL_W'(i_cfg.jitter_depth_ms) * JMUL_W'(US_PER_MS);
    assign w_dsum   = WIDE_W'(r_video) + WIDE_W'(w_jit_us) - WIDE_W'(r_audio);

    always_comb begin
        if (r_dfull > DRIFT_MAX64) begin
            n_drift = DRIFT_MAX64[DRIFT_W-1:0];
        end else if (r_dfull < DRIFT_MIN64) begin
            n_drift = DRIFT_MIN64[DRIFT_W-1:0];
        end else begin
            n_drift = r_dfull[DRIFT_W-1:0];
        end
    end

    assign w_mag = r_drift[DRIFT_W-1] ? (DRIFT_W'(0) - DRIFT_W'(r_drift)) : DRIFT_W'(r_drift);
    assign w_positive = !r_drift[DRIFT_W-1] && (r_drift != '0);

    always_comb begin
        if (w_mag < DRIFT_W'(i_cfg.correction_threshold)) begin
            n_corr = CORR_NONE;
        end else if (w_mag < DRIFT_W'(i_cfg.resample_threshold)) begin
            n_corr = w_positive ? CORR_STRETCH_AUDIO : CORR_SHRINK_AUDIO;
        end else begin
            n_corr = w_positive ? CORR_HOLD_VIDEO : CORR_DROP_VIDEO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_video  <= '0;
            r_audio  <= '0;
            r_drift  <= '0;
            r_corr   <= CORR_NONE;
            r_pos    <= '0;
            r_und    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // In S_OUT the valid flag is loaded below instead.
            if (r_ovalid && i_ready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_ts    <= i_ts;
                        r_delay <= i_delay;
                        if (i_ctl.xrun) begin
                            r_und <= r_und + UND_W'(1);
                        end
                        case (i_ctl.kind)
                            KIND_VIDEO: begin
                                r_video <= i_ts;
                                r_state <= S_DRIFT;
                            end
                            KIND_AUDIO_TIMED: begin
                                r_state <= S_MUL;
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_plo   <= w_plo;
                    r_phi   <= w_phi;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_dvd   <= DVD_W'(w_prod[SUM_W-1:DIV_SHIFT]);
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_v     <= w_v;
                    r_qdig  <= w_qdig;
                    r_dvd   <= {r_dvd[DVD_W-DIG_W-1:0], w_qdig};
                    r_state <= S_REM;
                end
                S_REM: begin
                    r_rem <= REM_W'(r_v - w_qd);
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_POS;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_POS: begin
                    r_pos   <= n_pos;
                    r_audio <= r_ts;
                    r_state <= S_DRIFT;
                end
                S_DRIFT: begin
                    // Drift and correction keep their old values until both
                    // timestamps are known.
                    if (w_both) begin
                        r_dfull <= w_dsum;
                        r_state <= S_SAT;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_SAT: begin
                    r_drift <= n_drift;
                    r_state <= S_CLASS;
                end
                S_CLASS: begin
                    r_corr  <= n_corr;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_odrift <= r_drift;
                        r_ocorr  <= r_corr;
                        r_opos   <= r_pos;
                        r_ound   <= r_und;
                        r_ordy   <= w_both;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid           = r_ovalid;
    assign o_drift_out       = r_odrift;
    assign o_correction      = r_ocorr;
    assign o_position_frames = r_opos;
    assign o_underruns       = r_ound;
    assign o_drift_ready     = r_ordy;

endmodule

>>> test/tb_av_sync_drift_classifier.sv
`timescale 1ns / 1ps

module tb_av_sync_drift_classifier;
    import avsdc_pkg::*;

    localparam int TIME_W = 44;
    localparam int RUN_LIMIT = 400000;
    localparam int RANDOM_PHASES = 5;
    localparam int EVENTS_PER_PHASE = 350;
    localparam logic ACT_VIDEO = 1'b0;
    localparam logic ACT_AUDIO = 1'b1;
    localparam logic [TIME_W-1:0] TS_MAX = '1;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam longint DRIFT_MAX = (longint'(1) <<< (DRIFT_W - 1)) - 1;
    localparam longint DRIFT_MIN = -DRIFT_MAX - 1;

    typedef struct {
        logic              action;
        logic [TIME_W-1:0] ts_us;
        logic [31:0]       delay;
        logic              xrun;
        logic              timing_ok;
    } t_av_event;

    typedef struct {
        logic signed [DRIFT_W-1:0] drift;
        t_corr                     corr;
        logic [POS_W-1:0]          pos;
        logic [UND_W-1:0]          underruns;
        logic                      ready;
    } t_sync_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_action = 1'b0;
    logic [TIME_W-1:0] i_timestamp_us = '0;
    logic signed [DELAY_W-1:0] i_delay_frames = '0;
    logic i_xrun = 1'b0;
    logic i_timing_valid = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [DRIFT_W-1:0] o_drift_out;
    logic [CORR_W-1:0] o_correction;
    logic [POS_W-1:0] o_position_frames;
    logic [UND_W-1:0] o_underruns;
    logic o_drift_ready;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    av_sync_drift_classifier #(
        .TIME_WIDTH(TIME_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_action(i_action),
        .i_timestamp_us(i_timestamp_us),
        .i_delay_frames(i_delay_frames),
        .i_xrun(i_xrun),
        .i_timing_valid(i_timing_valid),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_drift_out(o_drift_out),
        .o_correction(o_correction),
        .o_position_frames(o_position_frames),
        .o_underruns(o_underruns),
        .o_drift_ready(o_drift_ready),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // Predictor copy of the registers and of the tracking state.
    logic [RATE_W-1:0] rate_hz = SAMPLE_RATE_RST;
    logic [JIT_W-1:0] jitter_ms = JITTER_DEPTH_RST;
    logic [THR_W-1:0] corr_thr = CORRECTION_THR_RST;
    logic [THR_W-1:0] resamp_thr = RESAMPLE_THR_RST;
    logic [TIME_W-1:0] seen_video_us = '0;
    logic [TIME_W-1:0] seen_audio_us = '0;
    logic signed [DRIFT_W-1:0] drift_now = '0;
    t_corr corr_now = CORR_NONE;
    logic [POS_W-1:0] play_pos = '0;
    logic [UND_W-1:0] underrun_cnt = '0;

    t_av_event event_q[$];
    t_sync_result sync_result_q[$];
    logic [TIME_W-1:0] stream_us;
    bit beat_taken = 1'b0;
    bit calm = 1'b0;
    int mismatches = 0;
    int cycle_count = 0;

    always #5 i_clk = ~i_clk;

    function automatic void refresh_drift_class();
        longint d;
        longint mag;
        if (seen_video_us == 0 || seen_audio_us == 0)
            return;
        d = longint'(seen_video_us) + longint'(jitter_ms) * longint'(US_PER_MS)
            - longint'(seen_audio_us);
        if (d > DRIFT_MAX)
            d = DRIFT_MAX;
        if (d < DRIFT_MIN)
            d = DRIFT_MIN;
        mag = (d < 0) ? -d : d;
        drift_now = d[DRIFT_W-1:0];
        if (mag < longint'(corr_thr))
            corr_now = CORR_NONE;
        else if (mag < longint'(resamp_thr))
            corr_now = (d > 0) ? CORR_STRETCH_AUDIO : CORR_SHRINK_AUDIO;
        else
            corr_now = (d > 0) ? CORR_HOLD_VIDEO : CORR_DROP_VIDEO;
    endfunction

    function automatic t_sync_result predict_sync_result(input logic act,
                                                         input logic [TIME_W-1:0] ts,
                                                         input logic [31:0] dly,
                                                         input logic xr,
                                                         input logic tv);
        t_sync_result r;
        logic [63:0] frames;
        logic [63:0] dly_mag;
        if (act == ACT_VIDEO) begin
            seen_video_us = ts;
            refresh_drift_class();
        end else begin
            if (xr)
                underrun_cnt = underrun_cnt + UND_W'(1);
            if (tv) begin
                // A negative delay counts as no delay at all.
                dly_mag = dly[31] ? 64'd0 : 64'(dly);
                frames = (64'(ts) * 64'(rate_hz)) / 64'(US_PER_S);
                frames = (frames > dly_mag) ? frames - dly_mag : 64'd0;
                if (frames > 64'(POS_MAX))
                    frames = 64'(POS_MAX);
                seen_audio_us = ts;
                play_pos = frames[POS_W-1:0];
                refresh_drift_class();
            end
        end
        r.drift = drift_now;
        r.corr = corr_now;
        r.pos = play_pos;
        r.underruns = underrun_cnt;
        r.ready = (seen_video_us != 0) && (seen_audio_us != 0);
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endtask

    task automatic queue_event(input logic act, input logic [TIME_W-1:0] ts,
                               input logic [31:0] dly, input logic xr, input logic tv);
        t_av_event ev;
        ev.action = act;
        ev.ts_us = ts;
        ev.delay = dly;
        ev.xrun = xr;
        ev.timing_ok = tv;
        event_q.push_back(ev);
    endtask

    // Video beats move the stream clock on; audio beats sit at a chosen offset from it,
    // so the drift lands around both thresholds.
    function automatic t_av_event make_random_event();
        t_av_event ev;
        logic [TIME_W-1:0] mag;
        logic [THR_W-1:0] big;
        int pick;
        ev.action = 1'($urandom_range(0, 1));
        ev.xrun = ($urandom_range(0, 99) < 20);
        ev.timing_ok = ($urandom_range(0, 99) < 85);
        pick = $urandom_range(0, 99);
        if (pick < 10)
            ev.delay = $urandom;
        else if (pick < 18)
            ev.delay = -$urandom_range(1, 1000);
        else
            ev.delay = $urandom_range(0, 4800);
        big = (corr_thr > resamp_thr) ? corr_thr : resamp_thr;
        if ($urandom_range(0, 99) < 10) begin
            ev.ts_us = TIME_W'({$urandom, $urandom});
            ev.ts_us = ev.ts_us >> $urandom_range(0, TIME_W);
        end else if (ev.action == ACT_VIDEO) begin
            stream_us = stream_us + TIME_W'($urandom_range(0, 40000));
            ev.ts_us = stream_us;
        end else begin
            case ($urandom_range(0, 5))
                0: mag = TIME_W'(corr_thr);
                1: mag = TIME_W'(corr_thr) - TIME_W'(1);
                2: mag = TIME_W'(resamp_thr);
                3: mag = TIME_W'(resamp_thr) - TIME_W'(1);
                default: mag = TIME_W'($urandom_range(0, 2 * big + 1));
            endcase
            ev.ts_us = stream_us + TIME_W'(jitter_ms) * TIME_W'(US_PER_MS);
            ev.ts_us = $urandom_range(0, 1) ? ev.ts_us + mag : ev.ts_us - mag;
        end
        return ev;
    endfunction

    function automatic logic [31:0] pick_setting(input logic [1:0] idx);
        int c;
        c = $urandom_range(0, 6);
        case (idx)
            REG_SAMPLE_RATE: begin
                case (c)
                    0: return 32'd1;
                    1: return 32'd192000;
                    2: return 32'((1 << RATE_W) - 1);
                    3: return 32'd0;
                    default: return $urandom_range(1, 192000);
                endcase
            end
            REG_JITTER_DEPTH: begin
                case (c)
                    0: return 32'd5;
                    1: return 32'd1000;
                    2: return 32'((1 << JIT_W) - 1);
                    3: return 32'd0;
                    default: return $urandom_range(5, 1000);
                endcase
            end
            default: begin
                case (c)
                    0: return 32'd1;
                    1: return 32'd10000000;
                    2: return 32'((1 << THR_W) - 1);
                    3: return 32'd0;
                    4: return $urandom_range(1, 2000);
                    default: return $urandom_range(1, 100000);
                endcase
            end
        endcase
    endfunction

    task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] stored;
        case (idx)
            REG_SAMPLE_RATE: stored = 32'(val[RATE_W-1:0]);
            REG_JITTER_DEPTH: stored = 32'(val[JIT_W-1:0]);
            default: stored = 32'(val[THR_W-1:0]);
        endcase
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_SAMPLE_RATE: rate_hz = stored[RATE_W-1:0];
            REG_JITTER_DEPTH: jitter_ms = stored[JIT_W-1:0];
            REG_CORRECTION_THR: corr_thr = stored[THR_W-1:0];
            default: resamp_thr = stored[THR_W-1:0];
        endcase
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== stored)
            note_mismatch("register read back", 64'(stored), 64'(prdata));
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_until_idle();
        while (event_q.size() != 0 || i_valid || sync_result_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic configure(input logic [31:0] rate, input logic [31:0] jit,
                             input logic [31:0] cthr, input logic [31:0] rthr);
        wait_until_idle();
        write_register(REG_SAMPLE_RATE, rate);
        write_register(REG_JITTER_DEPTH, jit);
        write_register(REG_CORRECTION_THR, cthr);
        write_register(REG_RESAMPLE_THR, rthr);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || beat_taken) begin
            beat_taken = 1'b0;
            if (event_q.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
                t_av_event ev;
                ev = event_q.pop_front();
                i_valid <= 1'b1;
                i_action <= ev.action;
                i_timestamp_us <= ev.ts_us;
                i_delay_frames <= ev.delay;
                i_xrun <= ev.xrun;
                i_timing_valid <= ev.timing_ok;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_ready <= calm || ($urandom_range(0, 99) >= 10);
    end

    always @(posedge i_clk) begin
        t_sync_result want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                sync_result_q.push_back(predict_sync_result(i_action, i_timestamp_us,
                                                            i_delay_frames, i_xrun,
                                                            i_timing_valid));
                beat_taken = 1'b1;
            end
            if (o_valid && i_ready) begin
                if (sync_result_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result beat with nothing expected");
                end else begin
                    want = sync_result_q.pop_front();
                    if (o_drift_out !== want.drift)
                        note_mismatch("drift", 64'(want.drift), 64'(o_drift_out));
                    if (o_correction !== want.corr)
                        note_mismatch("correction", 64'(want.corr), 64'(o_correction));
                    if (o_position_frames !== want.pos)
                        note_mismatch("position", 64'(want.pos), 64'(o_position_frames));
                    if (o_underruns !== want.underruns)
                        note_mismatch("underruns", 64'(want.underruns), 64'(o_underruns));
                    if (o_drift_ready !== want.ready)
                        note_mismatch("drift ready", 64'(want.ready), 64'(o_drift_ready));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        stream_us = TIME_W'({$urandom, $urandom}) >> 4;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: readiness, underrun-only polls, negative and huge delays,
        // and drift right on both threshold edges.
        queue_event(ACT_VIDEO, '0, 32'd0, 1'b0, 1'b0);
        queue_event(ACT_AUDIO, TS_MAX, 32'd0, 1'b1, 1'b0);
        queue_event(ACT_AUDIO, '0, -32'sd5, 1'b0, 1'b1);
        queue_event(ACT_VIDEO, 44'd1000, 32'd0, 1'b0, 1'b0);
        queue_event(ACT_AUDIO, 44'd5000000, 32'd100, 1'b1, 1'b1);
        queue_event(ACT_VIDEO, 44'd4960000, 32'd0, 1'b0, 1'b0);
        queue_event(ACT_VIDEO, 44'd4961000, 32'd0, 1'b0, 1'b0);
        queue_event(ACT_VIDEO, 44'd4959000, 32'd0, 1'b0, 1'b0);
        queue_event(ACT_VIDEO, 44'd4980000, 32'd0, 1'b0, 1'b0);
        queue_event(ACT_VIDEO, 44'd4940001, 32'd0, 1'b0, 1'b0);
        queue_event(ACT_AUDIO, TS_MAX, 32'h7FFFFFFF, 1'b0, 1'b1);
        queue_event(ACT_VIDEO, TS_MAX, 32'hFFFFFFFF, 1'b1, 1'b0);
        queue_event(ACT_AUDIO, 44'd12345678, 32'h80000000, 1'b0, 1'b1);
        queue_event(ACT_AUDIO, '0, 32'd77, 1'b0, 1'b0);
        queue_event(ACT_AUDIO, 44'd1000, 32'd1000, 1'b0, 1'b1);

        // Widest rate saturates the position; zero thresholds class zero drift as a drop.
        configure(32'((1 << RATE_W) - 1), 32'd0, 32'd0, 32'd0);
        queue_event(ACT_AUDIO, TS_MAX, 32'd0, 1'b0, 1'b1);
        queue_event(ACT_VIDEO, TS_MAX, 32'd0, 1'b0, 1'b0);

        // Zero rate, deepest jitter and thresholds in the wrong order.
        configure(32'd0, 32'((1 << JIT_W) - 1), 32'((1 << THR_W) - 1), 32'd1);
        queue_event(ACT_AUDIO, 44'd20000000, 32'd10, 1'b0, 1'b1);
        queue_event(ACT_VIDEO, 44'd23977000, 32'd0, 1'b0, 1'b0);
        queue_event(ACT_VIDEO, 44'd1977000, 32'd0, 1'b0, 1'b0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            configure(pick_setting(REG_SAMPLE_RATE), pick_setting(REG_JITTER_DEPTH),
                      pick_setting(REG_CORRECTION_THR), pick_setting(REG_RESAMPLE_THR));
            calm = (p == 2);
            for (int n = 0; n < EVENTS_PER_PHASE; n++)
                event_q.push_back(make_random_event());
        end

        wait_until_idle();
        calm = 1'b0;
        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
